// File: src/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and codes of the selective-repeat sender window: request and
// response layouts, action and timer command codes, controller states.
// ----------------------------------------------------------------------------
package srsw_pkg;

   // Action codes carried by a request.
   typedef enum logic [1:0] {
      ACT_SEND    = 2'd0,
      ACT_ACK     = 2'd1,
      ACT_TIMEOUT = 2'd2
   } action_type;

   // Commands given to the external retransmission timers.
   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // One request: a send, an acknowledgement or a timer expiry.
   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] payload;
      logic [7:0]  ack_num;
      logic        checksum_ok;
      logic [2:0]  timeout_seq;
   } req_type;

   // One response: what was emitted, the timer command and the window state.
   typedef struct packed {
      logic        accepted;
      logic        tx_valid;
      logic [2:0]  tx_seq;
      logic [63:0] tx_payload;
      logic [1:0]  timer_cmd;
      logic [2:0]  timer_seq;
      logic [2:0]  window_base;
      logic [2:0]  next_seq;
      logic        window_full;
   } rsp_type;

endpackage

// File: src/srsw_chan_if.sv
// ----------------------------------------------------------------------------
// srsw_chan_if
// Valid/ready channel carrying one payload word of a chosen type.
// ----------------------------------------------------------------------------
interface srsw_chan_if #(
   parameter type data_type = logic
) ();

   logic     valid;
   logic     ready;
   data_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: src/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Simple dual-port synchronous memory: one write port, one read port with
// the read data registered.
// ----------------------------------------------------------------------------
module srsw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/selective_repeat_sender_window.sv
// Flow: a request is taken in the idle state, which starts its reads; the
// execute state carries out the action and the finish state registers the
// response once the output is free. No new request is taken before then. An
// ack at the base slides it in the scan state, one ack-mark read per slot.
// Reset: base and next sequence return to zero, then a pass clears every
// entry of the ack-mark memory, one entry a cycle, before the first request.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Selective-repeat ARQ sender window. Stores sent packets and their ack marks
// in synchronous memories, issues timer commands and slides the window base.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window import srsw_pkg::*; #(
   parameter int SEQ_COUNT    = 8,
   parameter int WINDOW_SIZE  = 4,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   srsw_chan_if.sink         req_chan,
   srsw_chan_if.source       rsp_chan
);

   localparam int SW = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;

   // Sequence arithmetic modulo SEQ_COUNT.
   function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
      return (s == SW'(SEQ_COUNT - 1)) ? '0 : s + SW'(1);
   endfunction

   function automatic logic [SW-1:0] seq_dist(input logic [SW-1:0] from_s,
                                               input logic [SW-1:0] to_s);
      logic [SW:0] d;
      if (to_s >= from_s) begin
         d = {1'b0, to_s} - {1'b0, from_s};
      end else begin
         d = {1'b0, to_s} + (SW+1)'(SEQ_COUNT) - {1'b0, from_s};
      end
      return d[SW-1:0];
   endfunction

   // Sequence index to the 3-bit field of the response.
   function automatic logic [2:0] seq_out(input logic [SW-1:0] s);
      logic [8:0] w;
      w = 9'(s);
      return w[2:0];
   endfunction

   state_type            state_ff, state_in;
   logic [SW-1:0]        clr_ff, clr_in;
   logic [SW-1:0]        base_ff, base_in;
   logic [SW-1:0]        send_ff, send_in;
   logic [SW-1:0]        scan_ff, scan_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        outst_ff, outst_in;

   // Latched request.
   logic [1:0]           act_ff, act_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [SW-1:0]        ack_idx_ff, ack_idx_in;
   logic                 ack_ok_ff, ack_ok_in;
   logic [SW-1:0]        tseq_idx_ff, tseq_idx_in;
   logic                 tseq_ok_ff, tseq_ok_in;

   // Partial result of the step.
   logic                 res_acc_ff, res_acc_in;
   logic                 res_txv_ff, res_txv_in;
   logic [SW-1:0]        res_txseq_ff, res_txseq_in;
   logic [PAYLOAD_BITS-1:0] res_txpay_ff, res_txpay_in;
   timer_cmd_type        res_tcmd_ff, res_tcmd_in;
   logic [SW-1:0]        res_tmseq_ff, res_tmseq_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                    mark_we;
   logic [SW-1:0]           mark_waddr;
   logic                    mark_wdata;
   logic [SW-1:0]           mark_raddr;
   logic                    mark_rdata;
   logic                    pkt_we;
   logic [SW-1:0]           pkt_waddr;
   logic [PAYLOAD_BITS-1:0] pkt_wdata;
   logic [SW-1:0]           pkt_raddr;
   logic [PAYLOAD_BITS-1:0] pkt_rdata;

   // Request decode at the input.
   logic [8:0]           req_ack9;
   logic [8:0]           req_tseq9;
   logic                 req_ack_rng;
   logic                 req_tseq_rng;
   logic                 req_take;

   // Step decode.
   logic [SW-1:0]        outst_now;
   logic                 full_now;
   logic                 ack_take;
   logic                 ack_at_base;
   logic                 out_free;
   logic [SW:0]          cnt_next;
   logic                 scan_more;

   srsw_ram #(
      .WIDTH (1),
      .DEPTH (SEQ_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

   srsw_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_COUNT)
   ) u_pkt_ram (
      .clock   (clock),
      .wr_en   (pkt_we),
      .wr_addr (pkt_waddr),
      .wr_data (pkt_wdata),
      .rd_addr (pkt_raddr),
      .rd_data (pkt_rdata)
   );

   // Input side: range checks and memory indexes of the incoming request.
   assign req_take     = req_chan.valid && (state_ff == ST_IDLE);
   assign req_ack9     = {1'b0, req_chan.payload.ack_num};
   assign req_tseq9    = {6'b0, req_chan.payload.timeout_seq};
   assign req_ack_rng  = req_ack9 < 9'(SEQ_COUNT);
   assign req_tseq_rng = req_tseq9 < 9'(SEQ_COUNT);

   // Window status and acknowledgement checks on the current state.
   assign outst_now   = seq_dist(base_ff, send_ff);
   assign full_now    = 32'(outst_now) >= WINDOW_SIZE;
   assign ack_take    = ack_ok_ff && !mark_rdata &&
                        (32'(seq_dist(base_ff, ack_idx_ff)) < WINDOW_SIZE);
   assign ack_at_base = ack_idx_ff == base_ff;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign cnt_next    = {1'b0, cnt_ff} + (SW+1)'(1);
   assign scan_more   = mark_rdata && (cnt_next < {1'b0, outst_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SW'(SEQ_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff == ACT_ACK && ack_take && ack_at_base &&
                outst_now > SW'(1)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (!scan_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath, memory accesses and response build.
   always_comb begin
      clr_in       = clr_ff;
      base_in      = base_ff;
      send_in      = send_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      outst_in     = outst_ff;
      act_in       = act_ff;
      pay_in       = pay_ff;
      ack_idx_in   = ack_idx_ff;
      ack_ok_in    = ack_ok_ff;
      tseq_idx_in  = tseq_idx_ff;
      tseq_ok_in   = tseq_ok_ff;
      res_acc_in   = res_acc_ff;
      res_txv_in   = res_txv_ff;
      res_txseq_in = res_txseq_ff;
      res_txpay_in = res_txpay_ff;
      res_tcmd_in  = res_tcmd_ff;
      res_tmseq_in = res_tmseq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      mark_we      = 1'b0;
      mark_waddr   = send_ff;
      mark_wdata   = 1'b0;
      mark_raddr   = seq_inc(scan_ff);
      pkt_we       = 1'b0;
      pkt_waddr    = send_ff;
      pkt_wdata    = pay_ff;
      pkt_raddr    = tseq_idx_ff;

      case (state_ff)
         // Clearing pass over the ack marks after reset.
         ST_CLEAR: begin
            mark_we    = 1'b1;
            mark_waddr = clr_ff;
            mark_wdata = 1'b0;
            clr_in     = seq_inc(clr_ff);
         end

         // Take the request and start the reads it needs.
         ST_IDLE: begin
            ack_idx_in  = req_ack_rng ? req_ack9[SW-1:0] : '0;
            tseq_idx_in = req_tseq_rng ? req_tseq9[SW-1:0] : '0;
            mark_raddr  = ack_idx_in;
            pkt_raddr   = tseq_idx_in;
            if (req_take) begin
               act_in     = req_chan.payload.action;
               pay_in     = req_chan.payload.payload[PAYLOAD_BITS-1:0];
               ack_ok_in  = req_ack_rng && req_chan.payload.checksum_ok;
               tseq_ok_in = req_tseq_rng;
            end
         end

         // Read data is back: carry out the action.
         ST_EXEC: begin
            res_acc_in   = 1'b0;
            res_txv_in   = 1'b0;
            res_txseq_in = '0;
            res_txpay_in = '0;
            res_tcmd_in  = TMR_NONE;
            res_tmseq_in = '0;
            mark_raddr   = seq_inc(base_ff);
            case (act_ff)
               ACT_SEND: begin
                  if (!full_now) begin
                     pkt_we       = 1'b1;
                     mark_we      = 1'b1;
                     res_acc_in   = 1'b1;
                     res_txv_in   = 1'b1;
                     res_txseq_in = send_ff;
                     res_txpay_in = pay_ff;
                     res_tcmd_in  = TMR_START;
                     res_tmseq_in = send_ff;
                     send_in      = seq_inc(send_ff);
                  end
               end
               ACT_ACK: begin
                  if (ack_take) begin
                     mark_we      = 1'b1;
                     mark_waddr   = ack_idx_ff;
                     mark_wdata   = 1'b1;
                     res_acc_in   = 1'b1;
                     res_tcmd_in  = TMR_STOP;
                     res_tmseq_in = ack_idx_ff;
                     if (ack_at_base) begin
                        if (outst_now > SW'(1)) begin
                           scan_in  = seq_inc(base_ff);
                           cnt_in   = SW'(1);
                           outst_in = outst_now;
                        end else begin
                           base_in = send_ff;
                        end
                     end
                  end
               end
               ACT_TIMEOUT: begin
                  if (tseq_ok_ff) begin
                     res_acc_in   = 1'b1;
                     res_txv_in   = 1'b1;
                     res_txseq_in = tseq_idx_ff;
                     res_txpay_in = pkt_rdata;
                     res_tcmd_in  = TMR_RESTART;
                     res_tmseq_in = tseq_idx_ff;
                  end
               end
               default: begin
                  res_acc_in = 1'b0;
               end
            endcase
         end

         // Slide the base over acknowledged slots, one mark per cycle.
         ST_SCAN: begin
            if (!mark_rdata) begin
               base_in = scan_ff;
            end else if (scan_more) begin
               scan_in = seq_inc(scan_ff);
               cnt_in  = cnt_next[SW-1:0];
            end else begin
               base_in = send_ff;
            end
         end

         // Hand the response to the output register.
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.accepted    = res_acc_ff;
               rsp_data_in.tx_valid    = res_txv_ff;
               rsp_data_in.tx_seq      = seq_out(res_txseq_ff);
               rsp_data_in.tx_payload  = 64'(res_txpay_ff);
               rsp_data_in.timer_cmd   = res_tcmd_ff;
               rsp_data_in.timer_seq   = seq_out(res_tmseq_ff);
               rsp_data_in.window_base = seq_out(base_ff);
               rsp_data_in.next_seq    = seq_out(send_ff);
               rsp_data_in.window_full = full_now;
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         send_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         send_ff      <= send_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      cnt_ff       <= cnt_in;
      outst_ff     <= outst_in;
      act_ff       <= act_in;
      pay_ff       <= pay_in;
      ack_idx_ff   <= ack_idx_in;
      ack_ok_ff    <= ack_ok_in;
      tseq_idx_ff  <= tseq_idx_in;
      tseq_ok_ff   <= tseq_ok_in;
      res_acc_ff   <= res_acc_in;
      res_txv_ff   <= res_txv_in;
      res_txseq_ff <= res_txseq_in;
      res_txpay_ff <= res_txpay_in;
      res_tcmd_ff  <= res_tcmd_in;
      res_tmseq_ff <= res_tmseq_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Channel outputs.
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

// File: src/srsw_checker.sv
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks of the sender window: response handshake, one request
// in flight at a time, idle after reset, and response field consistency.
// ----------------------------------------------------------------------------
module srsw_checker import srsw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its contents.
   assert property (@(posedge clock)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // Requests are processed one at a time.
   assert property (@(posedge clock)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // No request is taken in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during reset clearing");

   // A refused request emits nothing and gives no timer command.
   assert property (@(posedge clock)
      rsp_valid && !rsp_data.accepted |->
         !rsp_data.tx_valid && rsp_data.timer_cmd == TMR_NONE)
      else $error("refused request produced an action");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.payload)
);
